FILE: rtl/sine_lfo_tremolo_macros.svh
// Assertion macros used by the checker file.
`ifndef SINE_LFO_TREMOLO_MACROS_SVH
`define SINE_LFO_TREMOLO_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/slt_pkg.sv
package slt_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int PHASE_BITS  = 32;
	localparam int SINE_DEPTH  = 1024;
	localparam int ROM_ABITS   = $clog2(SINE_DEPTH);
	localparam int ROM_AW      = ROM_ABITS + 1;
	localparam int Q15_BITS    = 16;
	localparam int CFG_DW      = 32;
	localparam int DEPTH_BITS  = 7;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [CFG_DW-1:0] PHASE_STEP_RST = 32'd4473924;
	localparam logic [DEPTH_BITS-1:0] DEPTH_RST = 7'd50;

	// register indexes
	localparam logic CFG_PHASE_STEP = 1'b0;
	localparam logic CFG_DEPTH      = 1'b1;

	typedef logic [Q15_BITS-1:0] sine_rom_t [0:SINE_DEPTH];
	typedef logic [Q15_BITS-1:0] depth_tab_t [0:(1 << DEPTH_BITS) - 1];

	typedef struct packed {
		logic accept;    // take input frame, advance phase
		logic rom_rd;    // read sine magnitude and depth
		logic gain_calc; // form tremolo gain
		logic mul_left;  // left product into holding register
		logic load_out;  // right product and held left into output register
	} slt_cmd_t;

	// Quarter-wave sine, Q1.15, Taylor series to x^11 in Q30.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] r;
		longint sum;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			x = (64'(k) * HALF_PI_Q30) / SINE_DEPTH;
			x2 = (x * x) >> 30;
			t = x;
			sum = longint'(x);
			t = ((t * x2) >> 30) / 6;
			sum = sum - longint'(t);
			t = ((t * x2) >> 30) / 20;
			sum = sum + longint'(t);
			t = ((t * x2) >> 30) / 42;
			sum = sum - longint'(t);
			t = ((t * x2) >> 30) / 72;
			sum = sum + longint'(t);
			t = ((t * x2) >> 30) / 110;
			sum = sum - longint'(t);
			if (sum < 0) begin
				sum = 0;
			end
			r = ((64'(sum) * 64'd32768) + (64'd1 << 29)) >> 30;
			if (r > 64'd32768) begin
				r = 64'd32768;
			end
			rom[k] = r[Q15_BITS-1:0];
		end
		return rom;
	endfunction

	// Depth percent to Q15, saturating at 100.
	function automatic depth_tab_t build_depth_tab();
		depth_tab_t tab;
		int d;
		for (int i = 0; i < (1 << DEPTH_BITS); i++) begin
			d = (i > 100) ? 100 : i;
			tab[i] = Q15_BITS'((d * 32768 + 50) / 100);
		end
		return tab;
	endfunction

endpackage

FILE: rtl/slt_ctrl.sv
module slt_ctrl
	import slt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output slt_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_GAIN = 3'd2;
	localparam logic [2:0] ST_ML   = 3'd3;
	localparam logic [2:0] ST_MR   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       can_load;
	logic       accept;

	assign can_load = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_MR) && can_load);
	assign accept   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign cmd.accept    = accept;
	assign cmd.rom_rd    = (state_q == ST_RD);
	assign cmd.gain_calc = (state_q == ST_GAIN);
	assign cmd.mul_left  = (state_q == ST_ML);
	assign cmd.load_out  = (state_q == ST_MR) && can_load;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_RD;
			end
			ST_RD:   state_d = ST_GAIN;
			ST_GAIN: state_d = ST_ML;
			ST_ML:   state_d = ST_MR;
			ST_MR: begin
				if (can_load) state_d = accept ? ST_RD : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/slt_dp.sv
module slt_dp
	import slt_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  slt_cmd_t                      cmd,
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [CFG_DW-1:0]             cfg_wdata,
	input  logic signed [SAMPLE_BITS-1:0] in_left,
	input  logic signed [SAMPLE_BITS-1:0] in_right,
	output logic signed [SAMPLE_BITS-1:0] out_left,
	output logic signed [SAMPLE_BITS-1:0] out_right
);

	localparam sine_rom_t  SineRom  = build_sine_rom();
	localparam depth_tab_t DepthTab = build_depth_tab();
	localparam int PROD_W = SAMPLE_BITS + Q15_BITS + 1;
	localparam logic [ROM_AW-1:0] DEPTH_W = ROM_AW'(SINE_DEPTH);
	localparam logic [Q15_BITS:0] ONE_Q15 = (Q15_BITS + 1)'(32768);

	logic [CFG_DW-1:0]             phase_step_q;
	logic [DEPTH_BITS-1:0]         depth_pct_q;
	logic [PHASE_BITS-1:0]         lfo_phase_q;
	logic signed [SAMPLE_BITS-1:0] smp_l_q;
	logic signed [SAMPLE_BITS-1:0] smp_r_q;
	logic [ROM_AW-1:0]             rom_addr_q;
	logic                          neg_q;
	logic [Q15_BITS-1:0]           mag_q;
	logic [Q15_BITS-1:0]           dq_q;
	logic [Q15_BITS-1:0]           gain_q;
	logic signed [SAMPLE_BITS-1:0] prod_l_q;
	logic signed [SAMPLE_BITS-1:0] out_l_q;
	logic signed [SAMPLE_BITS-1:0] out_r_q;

	logic [ROM_ABITS-1:0]          pos;
	logic [ROM_AW-1:0]             rom_addr;
	logic [Q15_BITS:0]             lfo_sum;
	logic [2*Q15_BITS-1:0]         cut_prod;
	logic [2*Q15_BITS-1:0]         cut_rnd;
	logic [Q15_BITS:0]             gain_full;
	logic signed [SAMPLE_BITS-1:0] mul_a;
	logic signed [Q15_BITS:0]      mul_b;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-1:0]      prod_rnd;
	logic signed [SAMPLE_BITS-1:0] scaled;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= PHASE_STEP_RST;
			depth_pct_q  <= DEPTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_PHASE_STEP: phase_step_q <= cfg_wdata;
				CFG_DEPTH:      depth_pct_q  <= cfg_wdata[DEPTH_BITS-1:0];
				default: ;
			endcase
		end
	end

	// phase accumulator, advanced after the address is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_phase_q <= '0;
		end else if (cmd.accept) begin
			lfo_phase_q <= lfo_phase_q + phase_step_q[PHASE_BITS-1:0];
		end
	end

	// quadrant fold: odd quadrants read the table backwards
	assign pos = lfo_phase_q[PHASE_BITS-3 -: ROM_ABITS];
	assign rom_addr = lfo_phase_q[PHASE_BITS-2] ? (DEPTH_W - ROM_AW'(pos)) : ROM_AW'(pos);

	// gain = 1 - depth * (sin + 1) / 2
	assign lfo_sum   = neg_q ? (ONE_Q15 - (Q15_BITS + 1)'(mag_q))
	                         : (ONE_Q15 + (Q15_BITS + 1)'(mag_q));
	assign cut_prod  = dq_q * lfo_sum[Q15_BITS:1];
	assign cut_rnd   = cut_prod + (2 * Q15_BITS)'(16384);
	assign gain_full = ONE_Q15 - cut_rnd[2*Q15_BITS-1:15];

	// one shared multiplier, left then right
	assign mul_a    = cmd.mul_left ? smp_l_q : smp_r_q;
	assign mul_b    = $signed({1'b0, gain_q});
	assign prod     = mul_a * mul_b;
	assign prod_rnd = prod + PROD_W'(16384);
	assign scaled   = prod_rnd[SAMPLE_BITS+14:15];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			smp_l_q    <= in_left;
			smp_r_q    <= in_right;
			rom_addr_q <= rom_addr;
			neg_q      <= lfo_phase_q[PHASE_BITS-1];
		end
		if (cmd.rom_rd) begin
			mag_q <= SineRom[rom_addr_q];
			dq_q  <= DepthTab[depth_pct_q];
		end
		if (cmd.gain_calc) begin
			gain_q <= gain_full[Q15_BITS-1:0];
		end
		if (cmd.mul_left) begin
			prod_l_q <= scaled;
		end
		if (cmd.load_out) begin
			out_l_q <= prod_l_q;
			out_r_q <= scaled;
		end
	end

	assign out_left  = out_l_q;
	assign out_right = out_r_q;

endmodule

FILE: rtl/sine_lfo_tremolo.sv
// Stereo tremolo with a sine LFO.
// Input stream: one stereo frame per transaction on s_axis (tvalid/tready).
// Output stream: the scaled frame on m_axis, same packing, one per input.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr at the clock
//   edge; 0 = phase step per frame, 1 = depth in percent (above 100 acts as 100).
//   Write only while the block is idle.
// Pacing: one frame in flight at a time while the receiver keeps up; the pace
//   is set by the shared 24x17 multiplier (left, then right) behind the sine
//   table read and the gain multiply.
// The output register frees the input side: the next frame is taken in the
//   cycle the finished result moves to the output register, even while the
//   previous result there is still being delivered.
// Receiver stall: the result holds on m_axis; the frame behind it waits in its
//   last step and s_axis_tready stays low until the output register frees up.
// Reset (arst_n low): phase clears to zero, phase step and depth return to
//   their defaults (4473924 and 50 percent), nothing is pending on either side.
module sine_lfo_tremolo
	import slt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [47:0]       s_axis_tdata,  // [23:0] sample_left, [47:24] sample_right
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [47:0]       m_axis_tdata,  // [23:0] out_left, [47:24] out_right
	input  logic              cfg_we,
	input  logic              cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	slt_cmd_t                      cmd;
	logic signed [SAMPLE_BITS-1:0] out_left;
	logic signed [SAMPLE_BITS-1:0] out_right;

	// sequencer: accept, table read, gain, left product, right product
	slt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// phase accumulator, sine table, gain and sample scaling
	slt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_left   (s_axis_tdata[SAMPLE_BITS-1:0]),
		.in_right  (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.out_left  (out_left),
		.out_right (out_right)
	);

	assign m_axis_tdata = {out_right, out_left};

endmodule

FILE: rtl/slt_checker.sv
`include "sine_lfo_tremolo_macros.svh"

module slt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);

	// a stalled result holds its data
	`SLT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")

	// one frame in flight: no new transaction while the frame is in its table read, gain and left-product steps
	`SLT_ASSERT_NEXT(a_in_spacing, s_axis_tvalid && s_axis_tready, !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready, "input taken while a frame is in flight")

	// every accepted frame shows up at the output
	`SLT_ASSERT_NOW(a_out_follows, s_axis_tvalid && s_axis_tready, ##5 m_axis_tvalid, "no result after accepted frame")

endmodule

bind sine_lfo_tremolo slt_checker u_slt_checker (.*);

FILE: dv/tb.sv
// Testbench for the stereo sine-LFO tremolo.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import slt_pkg::*;

	localparam int QUIET_LIMIT = 5000;  // cycles with no transaction before giving up
	localparam int HOLD_CYCLES = 300;   // long receiver stall
	localparam int TAIL_CYCLES = 12;    // extra wait after the last expected frame
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 60;

	// {right, left}: left sits in the low bits, as on the bus
	typedef struct packed {
		logic [23:0] right;
		logic [23:0] left;
	} frame_t;

	typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic        addr;
		logic [31:0] val;
		frame_t      frame;
		bit          known;   // result typed in below, not predicted
		frame_t      result;
	} vec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_addr = 1'b0;
	logic [31:0] cfg_wdata = '0;

	sine_lfo_tremolo uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor: own copy of phase, step and depth, plus a quarter-wave
	// sine table built the same way the hardware ROM is specified.
	// ---------------------------------------------------------------
	logic [31:0] lfo_phase_q  = '0;
	logic [31:0] phase_step_q = 32'd4473924;
	logic [6:0]  depth_pct_q  = 7'd50;
	int          quarter_sine_tab [0:1024];

	frame_t pending_frames [$];   // expected scaled frames, oldest first
	int     errors = 0;
	bit     hold_req = 1'b0;      // ask the receiver for a long stall
	bit     rx_steady = 1'b0;     // receiver never idles while set

	// Taylor series of sin to x^11 in Q30, each term truncated, rounded to Q15
	function automatic int quarter_sine(int k);
		longint unsigned x, x2, term, r;
		longint          sum;
		x = (64'(k) * 64'd1686629713) / 64'd1024;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 5; n++) begin
			term = (term * x2) >> 30;
			term = term / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		r = 64'(sum);
		r = (r * 64'd32768 + (64'd1 << 29)) >> 30;
		if (r > 64'd32768) begin
			r = 64'd32768;
		end
		return int'(r);
	endfunction

	// Q15 gain 1 - depth*(sin+1)/2 for one phase
	function automatic int tremolo_gain(logic [31:0] ph, logic [6:0] pct);
		int k, mag, s, lfo, d, dq, cut;
		k = int'(ph[29:20]);
		mag = ph[30] ? quarter_sine_tab[1024 - k] : quarter_sine_tab[k];
		s = ph[31] ? -mag : mag;
		lfo = (s + 32768) / 2;
		d = (pct > 7'd100) ? 100 : int'(pct);   // depth saturates at 100 percent
		dq = (d * 32768 + 50) / 100;
		cut = (dq * lfo + 16384) >>> 15;
		if (cut > 32768) begin
			cut = 32768;
		end
		return 32768 - cut;
	endfunction

	// sample * gain, rounded half up (floor after adding half)
	function automatic logic [23:0] tremolo_scale(logic [23:0] smp, int gain);
		longint p;
		p = longint'($signed(smp)) * longint'(gain) + 64'sd16384;
		p = p >>> 15;
		return p[23:0];
	endfunction

	// gain comes from the current phase, then the phase moves on
	function automatic frame_t predict_frame(frame_t f);
		frame_t o;
		int     g;
		g = tremolo_gain(lfo_phase_q, depth_pct_q);
		o.left = tremolo_scale(f.left, g);
		o.right = tremolo_scale(f.right, g);
		lfo_phase_q = lfo_phase_q + phase_step_q;
		return o;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 50);
	endfunction

	// extremes and small values often, full range otherwise
	function automatic logic [23:0] pick_sample();
		logic [31:0] r;
		case ($urandom_range(0, 9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			3: return 24'hFFFFFF;
			4: return 24'h000001;
			default: begin
				r = $urandom;
				return r[23:0];
			end
		endcase
	endfunction

	function automatic vec_t cfg_row(logic addr, logic [31:0] val);
		vec_t v;
		v = '{kind: ROW_CFG, addr: addr, val: val, frame: '0, known: 1'b0, result: '0};
		return v;
	endfunction

	function automatic vec_t frame_row(logic [23:0] l, logic [23:0] r);
		vec_t v;
		v = '{kind: ROW_FRAME, addr: 1'b0, val: '0, frame: {r, l}, known: 1'b0, result: '0};
		return v;
	endfunction

	function automatic vec_t known_row(logic [23:0] l, logic [23:0] r,
			logic [23:0] el, logic [23:0] er);
		vec_t v;
		v = '{kind: ROW_FRAME, addr: 1'b0, val: '0, frame: {r, l}, known: 1'b1,
			result: {er, el}};
		return v;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus side. Everything is driven at the falling edge; handshakes
	// are sampled at the rising edge.
	// ---------------------------------------------------------------

	// one input transaction; the expectation is queued at the accepting edge
	task automatic send_frame(input frame_t f, input int gap, input bit known,
			input frame_t fixed);
		frame_t p;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= f;
		do @(posedge clk); while (!s_axis_tready);
		p = predict_frame(f);
		pending_frames = {pending_frames, (known ? fixed : p)};
	endtask

	// stop offering, let every expected frame come out, then a few cycles more
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_frames.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// single-cycle register write; the predictor copy follows it
	task automatic write_reg(input logic addr, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (addr == CFG_PHASE_STEP) begin
			phase_step_q = val;
		end else begin
			depth_pct_q = val[6:0];
		end
	endtask

	// ---------------------------------------------------------------
	// Receiver: random ready pattern, plus a long stall on request that
	// it times itself.
	// ---------------------------------------------------------------
	initial begin
		int hold_left, ready_left, gap_left;
		hold_left = 0;
		ready_left = 0;
		gap_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (rx_steady) begin
				gap_left = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (ready_left == 0) begin
					ready_left = $urandom_range(1, 30);
					gap_left = pick_gap();
				end
				ready_left--;
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Output check: every output transaction against the oldest expectation
	// ---------------------------------------------------------------
	frame_t oldest_frame;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_frames.size() == 0) begin
				$error("unexpected output frame %h", m_axis_tdata);
				errors++;
			end else begin
				oldest_frame = pending_frames.pop_front();
				if (m_axis_tdata[23:0] !== oldest_frame.left) begin
					$error("out_left: expected %0d, got %0d",
						$signed(oldest_frame.left), $signed(m_axis_tdata[23:0]));
					errors++;
				end
				if (m_axis_tdata[47:24] !== oldest_frame.right) begin
					$error("out_right: expected %0d, got %0d",
						$signed(oldest_frame.right), $signed(m_axis_tdata[47:24]));
					errors++;
				end
			end
		end
	end

	// Watchdog: too long without any transaction on either stream
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		vec_t        vecs [$];
		logic [31:0] step, dep;
		frame_t      f;

		for (int k = 0; k <= 1024; k++) begin
			quarter_sine_tab[k] = quarter_sine(k);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Phase starts at 0 after reset; the step rows below
		// bring it back to 0 and then walk it through the four quadrant starts,
		// where the gain is exactly 1/2, 0, 1/2 and 1 at full depth.
		// reset defaults, phase 0: gain 0.75
		vecs = {vecs, known_row(24'h7FFFFF, 24'h800000, 24'h5FFFFF, 24'hA00000)};
		vecs = {vecs, frame_row(24'h000001, 24'hFFFFFF)};
		vecs = {vecs, known_row(24'h000000, 24'h000000, 24'h000000, 24'h000000)};
		// zero depth: unity gain wherever the phase is
		vecs = {vecs, cfg_row(CFG_DEPTH, 32'd0)};
		vecs = {vecs, known_row(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000)};
		vecs = {vecs, known_row(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h000001)};
		// step of minus five defaults: phase wraps back to 0 after the next frame
		vecs = {vecs, cfg_row(CFG_PHASE_STEP, 32'hFEAAAAAC)};
		vecs = {vecs, known_row(24'h123456, 24'h9ABCDF, 24'h123456, 24'h9ABCDF)};
		// full depth, quarter-turn step
		vecs = {vecs, cfg_row(CFG_DEPTH, 32'd100)};
		vecs = {vecs, cfg_row(CFG_PHASE_STEP, 32'h40000000)};
		vecs = {vecs, known_row(24'h7FFFFF, 24'h800000, 24'h400000, 24'hC00000)};
		vecs = {vecs, known_row(24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000)};
		// half gain: rounding half up, on both signs; then unity gain
		vecs = {vecs, known_row(24'h000003, 24'hFFFFFD, 24'h000002, 24'hFFFFFF)};
		vecs = {vecs, known_row(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF)};
		// depth above 100 acts as 100
		vecs = {vecs, cfg_row(CFG_DEPTH, 32'd127)};
		vecs = {vecs, known_row(24'h000001, 24'hFFFFFF, 24'h000001, 24'h000000)};
		vecs = {vecs, known_row(24'h123456, 24'h9ABCDF, 24'h000000, 24'h000000)};
		vecs = {vecs, cfg_row(CFG_DEPTH, 32'd101)};
		vecs = {vecs, known_row(24'h000002, 24'hFFFFFE, 24'h000001, 24'hFFFFFF)};
		vecs = {vecs, known_row(24'h555555, 24'hD55555, 24'h555555, 24'hD55555)};
		// largest step: phase walks backwards through the last quadrant
		vecs = {vecs, cfg_row(CFG_PHASE_STEP, 32'hFFFFFFFF)};
		vecs = {vecs, cfg_row(CFG_DEPTH, 32'd73)};
		vecs = {vecs, frame_row(24'h7FFFFF, 24'h800000)};
		vecs = {vecs, frame_row(24'h800000, 24'h7FFFFF)};
		vecs = {vecs, frame_row(24'hAAAAAA, 24'h555555)};
		vecs = {vecs, frame_row(24'h000001, 24'hFFFFFF)};
		vecs = {vecs, cfg_row(CFG_PHASE_STEP, 32'h12345678)};
		vecs = {vecs, frame_row(24'h3C3C3C, 24'hC3C3C3)};
		vecs = {vecs, frame_row(24'hFFFFFF, 24'h000000)};

		foreach (vecs[i]) begin
			case (vecs[i].kind)
				ROW_CFG: begin
					drain();
					write_reg(vecs[i].addr, vecs[i].val);
				end
				default: begin
					send_frame(vecs[i].frame, pick_gap(), vecs[i].known, vecs[i].result);
				end
			endcase
		end

		// Random part: a new setting per phase, extremes first.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					step = 32'd0;           // frozen LFO
					dep = 32'd100;
				end
				1: begin
					step = 32'hFFFFFFFF;
					dep = 32'd0;
				end
				2: begin
					step = $urandom;
					dep = ($urandom & 32'hFFFFFF80) | 32'd127;  // junk above bit 6
				end
				3: begin
					step = $urandom_range(1, 1 << 16);
					dep = $urandom_range(0, 100);
				end
				default: begin
					step = $urandom;
					dep = $urandom_range(0, 127);
				end
			endcase
			drain();
			write_reg(CFG_PHASE_STEP, step);
			write_reg(CFG_DEPTH, dep);
			rx_steady = (p == 5);
			// phase 4: receiver stalls long while frames keep coming, input backs up
			if (p == 4) begin
				hold_req = 1'b1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 6 && i == PHASE_ITEMS / 2) begin
					drain();
				end
				f.left = pick_sample();
				f.right = pick_sample();
				send_frame(f, (p == 4 || p == 5) ? 0 : pick_gap(), 1'b0, '0);
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		rx_steady = 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/slt_pkg.sv
rtl/slt_ctrl.sv
rtl/slt_dp.sv
rtl/sine_lfo_tremolo.sv
rtl/slt_checker.sv
dv/tb.sv
